[sv/tmp_pkg.sv]
// shared types, codes and widths for the trapezoid move profile block
package tmp_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned StepWidth   = 16;
   localparam int unsigned OpWidth     = 2;
   localparam int unsigned PhaseWidth  = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned ProdWidth   = 2 * DataWidth;
   localparam int unsigned DenWidth    = DataWidth + 1;

   localparam logic [DataWidth-1:0] ALL_ONES = '1;

   // motion phase codes
   localparam logic [PhaseWidth-1:0] PH_STAND = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_ACCEL = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_FULL  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_DECEL = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_HELD  = 3'd4;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_PEAK = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RAMP = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MOVE = 2'd2;

   typedef enum logic [OpWidth-1:0] {
      OP_TICK     = 2'd0,
      OP_START    = 2'd1,
      OP_CONTINUE = 2'd2,
      OP_STOP     = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ACC_SPEED,
      S_DEC_SPEED,
      S_MUL_SPEED,
      S_TRAVEL,
      S_CHECK,
      S_SQUARE,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RATE_DT,
      MUL_SPEED_DT,
      MUL_SPEED_SQ,
      MUL_PEAK_SQ
   } mul_sel_type;

   typedef enum logic [2:0] {
      SPD_HOLD,
      SPD_ZERO,
      SPD_CRUISE,
      SPD_ADD,
      SPD_SUB
   } speed_op_type;

   typedef enum logic [2:0] {
      TRV_HOLD,
      TRV_ZERO,
      TRV_ADD,
      TRV_TARGET,
      TRV_CARRIED
   } trav_op_type;

   typedef struct packed {
      logic         load_item;
      mul_sel_type  mul_sel;
      speed_op_type speed_op;
      trav_op_type  trav_op;
      logic         start_move;
      logic         enter_full;
      logic         load_target_next;
      logic         load_den_half;
      logic         div_start;
      logic         load_accel;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      logic tr_ge_target;
      logic tr_ge_ramp;
      logic decel_point;
      logic speed_zero;
      logic ramp_cfg_zero;
      logic div_done;
   } stat_type;

endpackage

[sv/tmp_req_if.sv]
// request channel carrying one motion item
interface tmp_req_if;
   import tmp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OpWidth-1:0]   opcode;
   logic [StepWidth-1:0] time_step;
   logic                 hold_full_speed;
   logic [DataWidth-1:0] next_distance;
   logic [DataWidth-1:0] carried_distance;

   modport source (
      output valid, opcode, time_step, hold_full_speed, next_distance, carried_distance,
      input  ready
   );
   modport sink (
      input  valid, opcode, time_step, hold_full_speed, next_distance, carried_distance,
      output ready
   );
endinterface

[sv/tmp_rsp_if.sv]
// response channel carrying speed and phase
interface tmp_rsp_if;
   import tmp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DataWidth-1:0]  speed;
   logic [PhaseWidth-1:0] phase;

   modport source (output valid, speed, phase, input ready);
   modport sink (input valid, speed, phase, output ready);
endinterface

[sv/tmp_csr_if.sv]
// register write channel
interface tmp_csr_if;
   import tmp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [DataWidth-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/tmp_divider.sv]
// saturating restoring divider, 64-bit dividend by twice a 33-bit value
module tmp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmp_pkg::ProdWidth-1:0] dividend,
   input  logic [tmp_pkg::DenWidth-1:0]  divisor,
   output logic [tmp_pkg::DataWidth-1:0] quotient,
   output logic                          done
);
   import tmp_pkg::*;

   localparam int unsigned RemWidth = DenWidth + 1;
   localparam int unsigned CntWidth = $clog2(DataWidth);
   localparam logic [CntWidth-1:0] LastCnt = CntWidth'(DataWidth - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [RemWidth-1:0]  rem_ff, rem_in;
   logic [RemWidth-1:0]  dsr_ff, dsr_in;
   logic [DataWidth-1:0] quo_ff, quo_in;

   logic [RemWidth-1:0]  d2;
   logic [RemWidth-1:0]  hi_ext;
   logic [RemWidth:0]    trial;
   logic                 fits;

   assign d2     = {divisor, 1'b0};
   assign hi_ext = {2'b00, dividend[ProdWidth-1:DataWidth]};
   assign trial  = {rem_ff, quo_ff[DataWidth-1]};
   assign fits   = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         dsr_in = d2;
         cnt_in = '0;
         // high half at or above twice the divisor means the quotient overflows 32 bits
         if (hi_ext >= d2) begin
            quo_in  = ALL_ONES;
            done_in = 1'b1;
         end else begin
            rem_in  = hi_ext;
            quo_in  = dividend[DataWidth-1:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = RemWidth'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[RemWidth-1:0];
         end
         quo_in = {quo_ff[DataWidth-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[sv/tmp_datapath.sv]
// speed, distance and rate registers with the shared multiplier and divider
module tmp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [tmp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [tmp_pkg::DataWidth-1:0]   csr_data,
   input  logic [tmp_pkg::StepWidth-1:0]   time_step,
   input  logic [tmp_pkg::DataWidth-1:0]   next_distance,
   input  logic [tmp_pkg::DataWidth-1:0]   carried_distance,
   input  tmp_pkg::cmd_type                cmd,
   output tmp_pkg::stat_type               stat,
   output logic [tmp_pkg::DataWidth-1:0]   rsp_speed
);
   import tmp_pkg::*;

   localparam int unsigned StepLsb = StepWidth;
   localparam int unsigned StepMsb = StepWidth + DataWidth - 1;

   logic [DataWidth-1:0] peak_ff, peak_in;
   logic [DataWidth-1:0] ramp_cfg_ff, ramp_cfg_in;
   logic [DataWidth-1:0] move_ff, move_in;
   logic [StepWidth-1:0] dt_ff, dt_in;
   logic [DataWidth-1:0] next_ff, next_in;
   logic [DataWidth-1:0] carried_ff, carried_in;
   logic [DataWidth-1:0] speed_ff, speed_in;
   logic [DataWidth-1:0] trav_ff, trav_in;
   logic [DataWidth-1:0] accel_ff, accel_in;
   logic [DataWidth-1:0] cruise_ff, cruise_in;
   logic [DataWidth-1:0] ramp_used_ff, ramp_used_in;
   logic [DataWidth-1:0] target_ff, target_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic [ProdWidth-1:0] mul_ff, mul_in;
   logic [DataWidth-1:0] rsp_speed_ff, rsp_speed_in;

   logic [DataWidth-1:0] mul_a, mul_b;
   logic [DataWidth-1:0] step_term;
   logic [DataWidth-2:0] half_term;
   logic [DataWidth:0]   spd_sum, trav_sum;
   logic [DataWidth-1:0] spd_add, spd_sub, trav_add;
   logic [DataWidth-1:0] div_quotient;
   logic                 div_done;

   tmp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mul_ff),
      .divisor  (den_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // one shared multiplier; products with the step are Q16.16 times Q0.16
   always_comb begin
      case (cmd.mul_sel)
         MUL_RATE_DT: begin
            mul_a = accel_ff;
            mul_b = DataWidth'(dt_ff);
         end
         MUL_SPEED_DT: begin
            mul_a = speed_ff;
            mul_b = DataWidth'(dt_ff);
         end
         MUL_SPEED_SQ: begin
            mul_a = speed_ff;
            mul_b = speed_ff;
         end
         MUL_PEAK_SQ: begin
            mul_a = peak_ff;
            mul_b = peak_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in    = (cmd.mul_sel == MUL_NONE) ? mul_ff
                                                : ProdWidth'(mul_a) * ProdWidth'(mul_b);
   assign step_term = mul_ff[StepMsb:StepLsb];
   assign half_term = mul_ff[StepMsb:StepLsb+1];

   assign spd_sum  = {1'b0, speed_ff} + {1'b0, step_term};
   assign trav_sum = {1'b0, trav_ff} + {1'b0, step_term};
   assign spd_add  = spd_sum[DataWidth] ? ALL_ONES : spd_sum[DataWidth-1:0];
   assign trav_add = trav_sum[DataWidth] ? ALL_ONES : trav_sum[DataWidth-1:0];
   assign spd_sub  = (step_term >= speed_ff) ? '0 : speed_ff - step_term;

   always_comb begin
      peak_in     = peak_ff;
      ramp_cfg_in = ramp_cfg_ff;
      move_in     = move_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PEAK: peak_in     = csr_data;
            CSR_RAMP: ramp_cfg_in = csr_data;
            CSR_MOVE: move_in     = csr_data;
            default:  ;
         endcase
      end

      dt_in      = cmd.load_item ? time_step : dt_ff;
      next_in    = cmd.load_item ? next_distance : next_ff;
      carried_in = cmd.load_item ? carried_distance : carried_ff;

      case (cmd.speed_op)
         SPD_ZERO:   speed_in = '0;
         SPD_CRUISE: speed_in = cruise_ff;
         SPD_ADD:    speed_in = spd_add;
         SPD_SUB:    speed_in = spd_sub;
         default:    speed_in = speed_ff;
      endcase

      case (cmd.trav_op)
         TRV_ZERO:    trav_in = '0;
         TRV_ADD:     trav_in = trav_add;
         TRV_TARGET:  trav_in = target_ff;
         TRV_CARRIED: trav_in = carried_ff;
         default:     trav_in = trav_ff;
      endcase

      cruise_in    = cruise_ff;
      ramp_used_in = ramp_used_ff;
      target_in    = target_ff;
      den_in       = den_ff;
      if (cmd.start_move) begin
         cruise_in    = peak_ff;
         ramp_used_in = ramp_cfg_ff;
         target_in    = move_ff;
         den_in       = {1'b0, ramp_cfg_ff};
      end
      if (cmd.enter_full) begin
         cruise_in    = speed_ff;
         ramp_used_in = trav_ff;
      end
      if (cmd.load_target_next) begin
         target_in = next_ff;
      end
      // ramp plus half a step of travel at the current speed
      if (cmd.load_den_half) begin
         den_in = {1'b0, ramp_used_ff} + {2'b00, half_term};
      end

      accel_in     = cmd.load_accel ? div_quotient : accel_ff;
      rsp_speed_in = cmd.load_rsp ? speed_ff : rsp_speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         ramp_cfg_ff  <= '0;
         move_ff      <= '0;
         speed_ff     <= '0;
         trav_ff      <= '0;
         accel_ff     <= '0;
         cruise_ff    <= '0;
         ramp_used_ff <= '0;
         target_ff    <= '0;
      end else begin
         peak_ff      <= peak_in;
         ramp_cfg_ff  <= ramp_cfg_in;
         move_ff      <= move_in;
         speed_ff     <= speed_in;
         trav_ff      <= trav_in;
         accel_ff     <= accel_in;
         cruise_ff    <= cruise_in;
         ramp_used_ff <= ramp_used_in;
         target_ff    <= target_in;
      end
      dt_ff        <= dt_in;
      next_ff      <= next_in;
      carried_ff   <= carried_in;
      den_ff       <= den_in;
      mul_ff       <= mul_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign stat.tr_ge_target  = trav_ff >= target_ff;
   assign stat.tr_ge_ramp    = trav_ff >= ramp_used_ff;
   assign stat.decel_point   = ({1'b0, trav_ff} + {1'b0, ramp_used_ff}) >= {1'b0, target_ff};
   assign stat.speed_zero    = speed_ff == '0;
   assign stat.ramp_cfg_zero = ramp_cfg_ff == '0;
   assign stat.div_done      = div_done;

   assign rsp_speed = rsp_speed_ff;

endmodule

[sv/tmp_ctrl.sv]
// sequencing state machine, motion phase and response valid
module tmp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tmp_pkg::OpWidth-1:0]    req_opcode,
   input  logic                           req_hold,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tmp_pkg::PhaseWidth-1:0] rsp_phase,
   output tmp_pkg::cmd_type               cmd,
   input  tmp_pkg::stat_type              stat
);
   import tmp_pkg::*;

   state_type             state_ff, state_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   opcode_type            op_ff, op_in;
   logic                  hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PhaseWidth-1:0] rsp_phase_ff, rsp_phase_in;
   logic                  accept;
   logic                  out_free;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_STAND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      hold_ff      <= hold_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      hold_in      = hold_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd.load_item        = 1'b0;
      cmd.mul_sel          = MUL_NONE;
      cmd.speed_op         = SPD_HOLD;
      cmd.trav_op          = TRV_HOLD;
      cmd.start_move       = 1'b0;
      cmd.enter_full       = 1'b0;
      cmd.load_target_next = 1'b0;
      cmd.load_den_half    = 1'b0;
      cmd.div_start        = 1'b0;
      cmd.load_accel       = 1'b0;
      cmd.load_rsp         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = opcode_type'(req_opcode);
               hold_in       = req_hold;
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_START: begin
                  cmd.start_move = 1'b1;
                  cmd.speed_op   = SPD_ZERO;
                  cmd.trav_op    = TRV_ZERO;
                  cmd.mul_sel    = MUL_PEAK_SQ;
                  if (stat.ramp_cfg_zero) begin
                     phase_in = PH_FULL;
                  end else begin
                     state_in = S_DIV_START;
                  end
               end
               OP_CONTINUE: begin
                  if (phase_ff == PH_HELD) begin
                     cmd.load_target_next = 1'b1;
                     cmd.trav_op          = TRV_CARRIED;
                     phase_in             = PH_FULL;
                  end
               end
               OP_STOP: begin
                  cmd.speed_op = SPD_ZERO;
                  phase_in     = PH_STAND;
               end
               default: begin
                  case (phase_ff)
                     PH_ACCEL: begin
                        cmd.mul_sel = MUL_RATE_DT;
                        state_in    = S_ACC_SPEED;
                     end
                     PH_FULL: begin
                        cmd.speed_op = SPD_CRUISE;
                        state_in     = S_MUL_SPEED;
                     end
                     PH_DECEL: begin
                        cmd.mul_sel = MUL_RATE_DT;
                        state_in    = S_DEC_SPEED;
                     end
                     PH_STAND: cmd.speed_op = SPD_ZERO;
                     default:  ;
                  endcase
               end
            endcase
         end

         S_ACC_SPEED: begin
            cmd.speed_op = SPD_ADD;
            state_in     = S_MUL_SPEED;
         end

         S_DEC_SPEED: begin
            cmd.speed_op = SPD_SUB;
            state_in     = S_MUL_SPEED;
         end

         S_MUL_SPEED: begin
            cmd.mul_sel = MUL_SPEED_DT;
            state_in    = S_TRAVEL;
         end

         S_TRAVEL: begin
            cmd.trav_op = TRV_ADD;
            state_in    = S_CHECK;
         end

         S_CHECK: begin
            state_in = S_FINISH;
            case (phase_ff)
               PH_ACCEL, PH_FULL: begin
                  if (stat.tr_ge_target) begin
                     if (hold_ff) begin
                        phase_in = PH_HELD;
                     end else begin
                        cmd.trav_op  = TRV_TARGET;
                        cmd.speed_op = SPD_ZERO;
                        phase_in     = PH_STAND;
                     end
                  end else if (phase_ff == PH_ACCEL) begin
                     if (stat.tr_ge_ramp) begin
                        cmd.enter_full = 1'b1;
                        phase_in       = PH_FULL;
                     end
                  end else if (stat.decel_point && !hold_ff) begin
                     cmd.load_den_half = 1'b1;
                     state_in          = S_SQUARE;
                  end
               end
               PH_DECEL: begin
                  if (stat.tr_ge_target || stat.speed_zero) begin
                     cmd.trav_op  = TRV_TARGET;
                     cmd.speed_op = SPD_ZERO;
                     phase_in     = PH_STAND;
                  end
               end
               default: ;
            endcase
         end

         S_SQUARE: begin
            cmd.mul_sel = MUL_SPEED_SQ;
            state_in    = S_DIV_START;
         end

         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.load_accel = 1'b1;
               phase_in       = (op_ff == OP_START) ? PH_ACCEL : PH_DECEL;
               state_in       = S_FINISH;
            end
         end

         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_phase_in = phase_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_stand_has_no_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && phase_ff == PH_STAND) |-> stat.speed_zero)
      else $error("standing phase with nonzero speed");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside finish state");

endmodule

[sv/trapezoid_move_profile.sv]
// top level of the trapezoidal move profile generator
//
// req_chan takes one item per transfer: tick (integrate over time_step),
// start (load peak speed, ramp and move length from the registers),
// continue (resume a move held at full speed) or stop.
// every request gives exactly one transfer on rsp_chan with the speed and
// motion phase after that item. csr_chan writes peak_speed, ramp_distance
// and move_distance; it is always ready and is meant for idle periods.
// a request goes from decode straight to finish for stop, continue and
// ticks while standing or held; a tick at full speed passes the speed
// multiply, travel and check steps first, and an accelerating or
// decelerating tick adds a speed update before them; a start with a nonzero
// ramp runs the 32-step divider, as does the tick that begins braking after
// squaring the speed (the divider steps are skipped when the quotient
// saturates). one item is in flight at a time and the next request can
// transfer in the same cycle that rsp valid rises; braking is the slowest.
// a finished response sits in an output register, so the next request is
// taken while rsp_chan stalls; that request then waits at its last step
// until the register frees up.
// synchronous reset clears the configuration registers and motion state to
// zero and the phase to standing, and drops rsp valid.
module trapezoid_move_profile (
   input  logic        clock,
   input  logic        reset,
   tmp_req_if.sink     req_chan,
   tmp_rsp_if.source   rsp_chan,
   tmp_csr_if.sink     csr_chan
);
   import tmp_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_write;

   // register writes are always accepted and never stalled
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   // controller owns the handshakes, the motion phase and the sequencing
   tmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_opcode (req_chan.opcode),
      .req_hold   (req_chan.hold_full_speed),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_phase  (rsp_chan.phase),
      .cmd        (cmd),
      .stat       (stat)
   );

   // datapath holds speed, distance, rate state, the multiplier and divider
   tmp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .time_step        (req_chan.time_step),
      .next_distance    (req_chan.next_distance),
      .carried_distance (req_chan.carried_distance),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_speed        (rsp_chan.speed)
   );

endmodule
